FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the telemetry decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check on every rising edge outside reset.
`define DTD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check on every rising edge, reset included.
`define DTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DTD_ASSERT(lbl, clk, rstn, prop, msg)
`define DTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/dtd_pkg.sv
// ---------------------------------------------------------------------------
// dtd_pkg
// Types, constants and the GCR code table of the telemetry decoder.
// ---------------------------------------------------------------------------
package dtd_pkg;

	localparam int FRAME_BITS = 21;
	localparam int WORD_W     = 20;
	localparam int TAKEN_W    = 5;
	localparam int DUR_W      = 15;
	localparam int LEN_W      = 16;
	localparam int CNT_W      = 16;
	localparam int ERPM_W     = 20;
	localparam int PERIOD_W   = 16;
	localparam int DATA_W     = 12;
	localparam int DEC_W      = 16;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [LEN_W-1:0]  BIT_LEN_RESET = LEN_W'(53);
	localparam logic [ERPM_W-1:0] ERPM_SCALE    = ERPM_W'(1000000 * 60 / 100);
	localparam logic [DATA_W-1:0] STOP_CODE     = 12'hfff;
	localparam logic [3:0]        CSUM_GOOD     = 4'hf;

	// register index, taken from paddr[2]
	localparam logic REG_BIT_LEN = 1'b0;

	typedef struct packed {
		logic              start_bad;
		logic [WORD_W-1:0] word;
	} frame_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [TAKEN_W-1:0] taken;
	} shreg_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] nib;
	} gcr_nib_t;

	function automatic gcr_nib_t gcr_lookup(input logic [4:0] code);
		gcr_nib_t r;
		r.bad = 1'b0;
		unique case (code)
			5'd9:    r.nib = 4'd9;
			5'd10:   r.nib = 4'd10;
			5'd11:   r.nib = 4'd11;
			5'd13:   r.nib = 4'd13;
			5'd14:   r.nib = 4'd14;
			5'd15:   r.nib = 4'd15;
			5'd18:   r.nib = 4'd2;
			5'd19:   r.nib = 4'd3;
			5'd21:   r.nib = 4'd5;
			5'd22:   r.nib = 4'd6;
			5'd23:   r.nib = 4'd7;
			5'd25:   r.nib = 4'd0;
			5'd26:   r.nib = 4'd8;
			5'd27:   r.nib = 4'd1;
			5'd29:   r.nib = 4'd4;
			5'd30:   r.nib = 4'd12;
			default: begin
				r.bad = 1'b1;
				r.nib = 4'd0;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/dtd_if.sv
// ---------------------------------------------------------------------------
// dtd_if
// Valid/ready channels for received symbols and decoded telemetry words.
// ---------------------------------------------------------------------------
interface dtd_sym_if;
	logic       valid;
	logic       ready;
	logic       first_level;
	logic [14:0] first_duration;
	logic       second_level;
	logic [14:0] second_duration;
	logic       last_symbol;

	modport source (
		output valid, first_level, first_duration, second_level, second_duration,
			last_symbol,
		input  ready
	);
	modport sink (
		input  valid, first_level, first_duration, second_level, second_duration,
			last_symbol,
		output ready
	);
endinterface

interface dtd_res_if;
	logic        valid;
	logic        ready;
	logic [19:0] erpm_x100;
	logic        valid_res;
	logic [19:0] raw_gcr;

	modport source (
		output valid, erpm_x100, valid_res, raw_gcr,
		input  ready
	);
	modport sink (
		input  valid, erpm_x100, valid_res, raw_gcr,
		output ready
	);
endinterface

FILE: rtl/core/dshot_telemetry_decoder.sv
// ---------------------------------------------------------------------------
// dshot_telemetry_decoder
// Bidirectional DShot eRPM telemetry decoder with APB bit-length register.
// ---------------------------------------------------------------------------
// Usage:
//   sym  - one word per received symbol: two level/duration halves and a flag
//          on the final symbol of the frame. A zero duration ends the frame.
//   res  - one word per frame: eRPM/100, a good-frame flag and the raw GCR
//          word after transition decoding.
//   APB  - register 0 (byte address 0) holds the bit length in timer ticks,
//          reset value 53. Write it only while the block is idle.
// Symbol steps: accept, bit-serial duration division, then the shifts of both
//   levels, the second skipped when the second duration is zero; a symbol after
//   a zero duration is only accepted. The final symbol adds a step to queue the
//   frame, and a new symbol is taken only once the last one is through.
// Result steps: queue read, GCR check, eRPM division, output load; the
//   division is skipped when the word is rejected or carries the stop code.
// A two-entry frame queue and the output register let the symbol side keep
//   accepting while the receiver stalls; when both are full, sym.ready stays
//   low after a final symbol until the queue has room. Reset clears the
//   frame in progress, the queue and output word, and restores bit length.
// ---------------------------------------------------------------------------
module dshot_telemetry_decoder import dtd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	dtd_sym_if.sink            sym,
	dtd_res_if.source          res
);

	logic [LEN_W-1:0] bit_len_q;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	frame_t           push_entry;
	frame_t           pop_entry;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BIT_LEN) ? PDATA_W'(bit_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_len_q <= BIT_LEN_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_LEN)) begin
			bit_len_q <= pwdata[LEN_W-1:0];
		end
	end

	dtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym        (sym),
		.bit_len    (bit_len_q),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	dtd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	dtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

FILE: rtl/core/dtd_div.sv
// ---------------------------------------------------------------------------
// dtd_div
// Restoring divider, one quotient bit per cycle, quotient held until restart.
// ---------------------------------------------------------------------------
module dtd_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [STEP_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= STEP_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

FILE: rtl/core/dtd_fifo.sv
// ---------------------------------------------------------------------------
// dtd_fifo
// Short frame queue between the symbol front end and the word decoder.
// ---------------------------------------------------------------------------
module dtd_fifo import dtd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_entry,
	output logic   full,
	input  logic   pop,
	output frame_t pop_entry,
	output logic   empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	frame_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty     = (fill_q == '0);
	assign pop_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + FILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: rtl/core/dtd_front.sv
// ---------------------------------------------------------------------------
// dtd_front
// Symbol front end: converts durations to bit counts, shifts the levels in
// and hands each finished 20-bit frame to the queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtd_front import dtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dtd_sym_if.sink           sym,
	input  logic [LEN_W-1:0]  bit_len,
	output logic              push,
	output frame_t            push_entry,
	input  logic              full
);

	typedef enum logic [2:0] {F_IDLE, F_DIV, F_SHIFT0, F_SHIFT1, F_FINISH} state_t;

	state_t     state_q;
	shreg_t     acc_q;
	logic       stopped_q;
	logic       at_start_q;
	logic       start_bad_q;
	logic       l0_q;
	logic       l1_q;
	logic       last_q;
	logic       d1_zero_q;

	logic             accept;
	logic             d0_nz;
	logic             div_start;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] num0;
	logic [LEN_W-1:0] num1;
	logic [CNT_W-1:0] quo0;
	logic [CNT_W-1:0] quo1;
	logic             div_done;
	logic             div_done1;
	shreg_t           sh0;
	shreg_t           sh1;
	shreg_t           filled;
	logic [CNT_W-1:0] n_fill;
	logic [WORD_W-1:0] tword;

	function automatic shreg_t shift_in(input shreg_t cur, input logic level,
		input logic [CNT_W-1:0] n);
		shreg_t            r;
		logic [CNT_W:0]    t;
		logic [WORD_W-1:0] fill;
		r    = cur;
		t    = {1'b0, n} + (CNT_W + 1)'(cur.taken);
		fill = level ? ~({WORD_W{1'b1}} << n[TAKEN_W-1:0]) : '0;
		if (n != '0) begin
			if (n >= CNT_W'(WORD_W))
				r.word = level ? '1 : '0;
			else
				r.word = (cur.word << n[TAKEN_W-1:0]) | fill;
			r.taken = (t > (CNT_W + 1)'(FRAME_BITS)) ? TAKEN_W'(FRAME_BITS)
				: t[TAKEN_W-1:0];
		end
		return r;
	endfunction

	assign sym.ready = (state_q == F_IDLE);
	assign accept    = sym.valid && sym.ready;
	assign d0_nz     = (sym.first_duration != '0);
	assign div_start = accept && !stopped_q && d0_nz;

	// a zero bit length behaves as one tick; round to nearest
	assign len  = (bit_len == '0) ? LEN_W'(1) : bit_len;
	assign num0 = LEN_W'(sym.first_duration) + (len >> 1);
	assign num1 = LEN_W'(sym.second_duration) + (len >> 1);

	dtd_div #(.NUM_W(LEN_W), .DEN_W(LEN_W)) u_div0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num0),
		.den    (len),
		.done   (div_done),
		.quo    (quo0)
	);

	dtd_div #(.NUM_W(LEN_W), .DEN_W(LEN_W)) u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num1),
		.den    (len),
		.done   (div_done1),
		.quo    (quo1)
	);

	assign sh0 = shift_in(acc_q, l0_q, quo0);
	assign sh1 = shift_in(acc_q, l1_q, quo1);

	// pad a short frame with ones, then undo the transition coding
	assign n_fill = CNT_W'(FRAME_BITS) - CNT_W'(acc_q.taken);
	assign filled = shift_in(acc_q, 1'b1, n_fill);
	assign tword  = filled.word ^ (filled.word >> 1);

	assign push                 = (state_q == F_FINISH) && !full;
	assign push_entry.start_bad = start_bad_q;
	assign push_entry.word      = start_bad_q ? '0 : tword;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			acc_q       <= '0;
			stopped_q   <= 1'b0;
			at_start_q  <= 1'b1;
			start_bad_q <= 1'b0;
			l0_q        <= 1'b0;
			l1_q        <= 1'b0;
			last_q      <= 1'b0;
			d1_zero_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						l0_q      <= sym.first_level;
						l1_q      <= sym.second_level;
						last_q    <= sym.last_symbol;
						d1_zero_q <= (sym.second_duration == '0);
						if (at_start_q)
							start_bad_q <= sym.first_level;
						at_start_q <= 1'b0;
						if (!stopped_q && d0_nz) begin
							state_q <= F_DIV;
						end else begin
							if (!d0_nz)
								stopped_q <= 1'b1;
							state_q <= sym.last_symbol ? F_FINISH : F_IDLE;
						end
					end
				end
				F_DIV: begin
					if (div_done)
						state_q <= F_SHIFT0;
				end
				F_SHIFT0: begin
					acc_q <= sh0;
					if (d1_zero_q) begin
						stopped_q <= 1'b1;
						state_q   <= last_q ? F_FINISH : F_IDLE;
					end else begin
						state_q <= F_SHIFT1;
					end
				end
				F_SHIFT1: begin
					acc_q   <= sh1;
					state_q <= last_q ? F_FINISH : F_IDLE;
				end
				F_FINISH: begin
					// hold until the queue has room, then start a fresh frame
					if (!full) begin
						acc_q       <= '0;
						stopped_q   <= 1'b0;
						at_start_q  <= 1'b1;
						start_bad_q <= 1'b0;
						state_q     <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`DTD_ASSERT(a_taken_sat, clk, arst_n, acc_q.taken <= TAKEN_W'(FRAME_BITS), "bit count past frame length")
	`DTD_ASSERT(a_div_in_div, clk, arst_n, (div_done || div_done1) |-> (state_q == F_DIV), "division finished outside wait state")
	`DTD_ASSERT(a_start_seen, clk, arst_n, (state_q != F_IDLE) |-> !at_start_q, "symbol in work while frame start still pending")

endmodule

FILE: rtl/core/dtd_back.sv
// ---------------------------------------------------------------------------
// dtd_back
// Word decoder: GCR and checksum check, period expansion, eRPM division and
// the output register of the result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtd_back import dtd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  frame_t    pop_entry,
	input  logic      empty,
	output logic      pop,
	dtd_res_if.source res
);

	typedef enum logic [1:0] {B_IDLE, B_DEC, B_DIV, B_OUT} state_t;

	state_t            state_q;
	frame_t            frame_q;
	logic              ok_q;
	logic [WORD_W-1:0] raw_q;
	logic [ERPM_W-1:0] erpm_q;
	logic              res_valid_q;
	logic [ERPM_W-1:0] res_erpm_q;
	logic              res_ok_q;
	logic [WORD_W-1:0] res_raw_q;

	gcr_nib_t          g0, g1, g2, g3;
	logic [DEC_W-1:0]  dec;
	logic [3:0]        csum;
	logic [DATA_W-1:0] data;
	logic [PERIOD_W-1:0] period;
	logic              is_stop;
	logic              ok;
	logic              need_div;
	logic              div_start;
	logic [ERPM_W-1:0] num;
	logic              div_done;
	logic [ERPM_W-1:0] quo;

	assign g0 = gcr_lookup(frame_q.word[4:0]);
	assign g1 = gcr_lookup(frame_q.word[9:5]);
	assign g2 = gcr_lookup(frame_q.word[14:10]);
	assign g3 = gcr_lookup(frame_q.word[19:15]);
	assign dec     = {g3.nib, g2.nib, g1.nib, g0.nib};
	assign csum    = dec[3:0] ^ dec[7:4] ^ dec[11:8] ^ dec[15:12];
	assign data    = dec[15:4];
	assign is_stop = (data == STOP_CODE);
	assign period  = PERIOD_W'(data[8:0]) << data[11:9];

	assign ok = !frame_q.start_bad && (frame_q.word != '0)
		&& !(g0.bad || g1.bad || g2.bad || g3.bad)
		&& (csum == CSUM_GOOD) && (is_stop || (period != '0));
	assign need_div = ok && !is_stop;

	assign div_start = (state_q == B_DEC) && need_div;
	assign num       = ERPM_SCALE + ERPM_W'(period >> 1);

	dtd_div #(.NUM_W(ERPM_W), .DEN_W(PERIOD_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (period),
		.done   (div_done),
		.quo    (quo)
	);

	assign pop = (state_q == B_IDLE) && !empty;

	assign res.valid     = res_valid_q;
	assign res.erpm_x100 = res_erpm_q;
	assign res.valid_res = res_ok_q;
	assign res.raw_gcr   = res_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			frame_q     <= '0;
			ok_q        <= 1'b0;
			raw_q       <= '0;
			erpm_q      <= '0;
			res_valid_q <= 1'b0;
			res_erpm_q  <= '0;
			res_ok_q    <= 1'b0;
			res_raw_q   <= '0;
		end else begin
			if (res_valid_q && res.ready && (state_q != B_OUT))
				res_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						frame_q <= pop_entry;
						state_q <= B_DEC;
					end
				end
				B_DEC: begin
					ok_q    <= ok;
					raw_q   <= frame_q.word;
					erpm_q  <= '0;
					state_q <= need_div ? B_DIV : B_OUT;
				end
				B_DIV: begin
					if (div_done) begin
						erpm_q  <= quo;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					// load the output word once the previous one has left
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_erpm_q  <= ok_q ? erpm_q : '0;
						res_ok_q    <= ok_q;
						res_raw_q   <= raw_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`DTD_ASSERT(a_bad_zero, clk, arst_n, (res_valid_q && !res_ok_q) |-> (res_erpm_q == '0), "invalid word carries nonzero eRPM")
	`DTD_ASSERT(a_div_wait, clk, arst_n, div_done |-> (state_q == B_DIV), "division finished outside wait state")
	`DTD_ASSERT(a_div_ok, clk, arst_n, (state_q == B_DIV) |-> ok_q, "division started for a rejected word")

endmodule
